// ===== src/mtfel_pkg.sv =====
package mtfel_pkg;

  localparam int Entries  = 8;
  localparam int KeyBytes = 7;
  localparam int KeyW     = 56;
  localparam int LenW     = 3;
  localparam int PosW     = 3;
  localparam int IdxW     = $clog2(Entries);

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_READ   = 1'b1
  } op_e;

  typedef enum logic {
    STATUS_OK      = 1'b0,
    STATUS_BAD_LEN = 1'b1
  } status_e;

  typedef logic [KeyW-1:0] key_t;
  typedef logic [LenW-1:0] len_t;

  function automatic key_t byte_mask(input len_t len);
    key_t m;
    m = '0;
    for (int b = 0; b < KeyW / 8; b++) begin
      if (b < int'(len)) begin
        m[b*8 +: 8] = 8'hff;
      end
    end
    return m;
  endfunction

endpackage

// ===== src/move_to_front_entry_list.sv =====
// Channel   Direction  Handshake               Payload
// request   in         in_valid_i / in_stall_o operation_i key_i key_len_i row_index_i
// result    out        out_valid_o / out_stall_i status_o hit_o hit_position_o row_key_o row_len_o
//
// One request per cycle while in_stall_o is low; a taken request passes the input register, then the result register.
// The row compare, move and shift of all rows are combinational from the input register and are stored with the result.
// Reset clears every row to empty and empties both pipeline registers.
// A stalled result holds its stage; a waiting request is held in the input register.
module move_to_front_entry_list
  import mtfel_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            operation_i,
  input  logic [KeyW-1:0] key_i,
  input  logic [LenW-1:0] key_len_i,
  input  logic [2:0]      row_index_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic            status_o,
  output logic            hit_o,
  output logic [PosW-1:0] hit_position_o,
  output logic [KeyW-1:0] row_key_o,
  output logic [LenW-1:0] row_len_o
);

  logic            s1_valid_q;
  op_e             s1_op_q;
  key_t            s1_key_q;
  len_t            s1_len_q;
  logic [2:0]      s1_idx_q;

  key_t            keys_q [Entries];
  len_t            lens_q [Entries];

  logic            out_valid_q;
  logic            status_q;
  logic            hit_q;
  logic [PosW-1:0] hpos_q;
  key_t            rkey_q;
  len_t            rlen_q;

  logic            adv;
  logic            len_ok;
  logic            ins_ok;
  key_t            kmask;
  logic            found_hit;
  logic [IdxW-1:0] found;
  logic [IdxW-1:0] limit;
  logic            status_d;
  logic            hit_d;
  logic [PosW-1:0] hpos_d;
  key_t            rkey_d;
  len_t            rlen_d;
  logic            gap;

  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_op_q  <= op_e'(operation_i);
      s1_key_q <= key_i;
      s1_len_q <= key_len_i;
      s1_idx_q <= row_index_i;
    end
  end

  always_comb begin
    len_ok    = (s1_len_q != '0) && (int'(s1_len_q) <= KeyBytes);
    ins_ok    = (s1_op_q == OP_INSERT) && len_ok;
    kmask     = byte_mask(s1_len_q);
    found_hit = 1'b0;
    found     = '0;
    for (int r = Entries - 1; r >= 0; r--) begin
      if (lens_q[r] == s1_len_q && (keys_q[r] & kmask) == (s1_key_q & kmask)) begin
        found_hit = 1'b1;
        found     = IdxW'(r);
      end
    end
    limit = found_hit ? found : IdxW'(Entries - 1);

    status_d = STATUS_OK;
    hit_d    = 1'b0;
    hpos_d   = '0;
    rkey_d   = '0;
    rlen_d   = '0;
    if (s1_op_q == OP_READ) begin
      for (int r = 0; r < Entries; r++) begin
        if (int'(s1_idx_q) == r && lens_q[r] != '0) begin
          rkey_d = keys_q[r];
          rlen_d = lens_q[r];
        end
      end
    end else if (!len_ok) begin
      status_d = STATUS_BAD_LEN;
    end else if (found_hit) begin
      hit_d  = 1'b1;
      hpos_d = PosW'(found);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < Entries; r++) begin
        keys_q[r] <= '0;
        lens_q[r] <= '0;
      end
    end else if (s1_valid_q && adv && ins_ok) begin
      keys_q[0] <= s1_key_q & kmask;
      lens_q[0] <= s1_len_q;
      for (int r = 1; r < Entries; r++) begin
        if (r <= int'(limit)) begin
          keys_q[r] <= keys_q[r-1];
          lens_q[r] <= lens_q[r-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_valid_q) begin
      status_q <= status_d;
      hit_q    <= hit_d;
      hpos_q   <= hpos_d;
      rkey_q   <= rkey_d;
      rlen_q   <= rlen_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign hit_o          = hit_q;
  assign hit_position_o = hpos_q;
  assign row_key_o      = rkey_q;
  assign row_len_o      = rlen_q;

  always_comb begin
    gap = 1'b0;
    for (int r = 1; r < Entries; r++) begin
      if (lens_q[r] != '0 && lens_q[r-1] == '0) begin
        gap = 1'b1;
      end
    end
  end

  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni) !gap)
    else $error("empty row ahead of a filled row");

  a_front_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && adv && ins_ok) |=> lens_q[0] == $past(s1_len_q))
    else $error("front row does not hold the inserted key");

  a_bad_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(status_q && hit_q))
    else $error("hit reported on a rejected insert");

  a_read_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && rlen_q != '0) |-> (!hit_q && !status_q))
    else $error("insert flags set on a read result");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i && s1_valid_q) |=> (s1_valid_q && $stable(s1_key_q)))
    else $error("held request lost while result stalled");

endmodule

// ===== bench/mru_list_checker.sv =====
`timescale 1ns / 1ps

module mru_list_checker
  import mtfel_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_stall_o,
  input  logic            operation_i,
  input  key_t            key_i,
  input  len_t            key_len_i,
  input  logic [2:0]      row_index_i,
  input  logic            out_valid_o,
  input  logic            out_stall_i,
  input  logic            status_o,
  input  logic            hit_o,
  input  logic [PosW-1:0] hit_position_o,
  input  key_t            row_key_o,
  input  len_t            row_len_o,
  output int              error_count,
  output int              pending,
  output int              insert_count,
  output int              hit_count,
  output int              bad_len_count,
  output int              read_count,
  output int              stall_cycles
);

  typedef struct packed {
    status_e         status;
    logic            hit;
    logic [PosW-1:0] position;
    key_t            row_key;
    len_t            row_len;
  } mru_result_t;

  key_t        row_keys[Entries];
  len_t        row_lens[Entries];
  mru_result_t awaited_results[$];

  function automatic key_t leading_bytes(input key_t k, input len_t n);
    logic [63:0] m;
    m = (64'd1 << (8 * n)) - 64'd1;
    return k & m[KeyW-1:0];
  endfunction

  task automatic predict_mru_access(input op_e op, input key_t key, input len_t len,
                                    input logic [2:0] idx, output mru_result_t res);
    key_t k;
    key_t nk[Entries];
    len_t nl[Entries];
    int   found;
    int   w;
    res = '0;
    if (op == OP_READ) begin
      if (int'(idx) < Entries && row_lens[idx] != '0) begin
        res.row_key = row_keys[idx];
        res.row_len = row_lens[idx];
      end
    end else if (len == '0 || int'(len) > KeyBytes) begin
      res.status = STATUS_BAD_LEN;
    end else begin
      k     = leading_bytes(key, len);
      found = -1;
      for (int r = 0; r < Entries; r++) begin
        if (found < 0 && row_lens[r] == len && leading_bytes(row_keys[r], len) == k) begin
          found = r;
        end
      end
      if (found >= 0) begin
        res.hit      = 1'b1;
        res.position = found[PosW-1:0];
        if (found != 0) begin
          // move the hit row to the front, keep the other live rows in order
          for (int r = 0; r < Entries; r++) begin
            nk[r] = '0;
            nl[r] = '0;
          end
          nk[0] = k;
          nl[0] = len;
          w = 1;
          for (int r = 0; r < Entries; r++) begin
            if (r != found && row_lens[r] != '0 && w < Entries) begin
              nk[w] = row_keys[r];
              nl[w] = row_lens[r];
              w++;
            end
          end
          for (int r = 0; r < Entries; r++) begin
            row_keys[r] = nk[r];
            row_lens[r] = nl[r];
          end
        end
      end else begin
        for (int r = Entries - 1; r > 0; r--) begin
          row_keys[r] = row_keys[r-1];
          row_lens[r] = row_lens[r-1];
        end
        row_keys[0] = k;
        row_lens[0] = len;
      end
    end
  endtask

  task automatic compare_field(input string name, input logic [KeyW-1:0] want,
                               input logic [KeyW-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    mru_result_t want;
    if (!rst_ni) begin
      for (int r = 0; r < Entries; r++) begin
        row_keys[r] = '0;
        row_lens[r] = '0;
      end
      awaited_results.delete();
      error_count   = 0;
      insert_count  = 0;
      hit_count     = 0;
      bad_len_count = 0;
      read_count    = 0;
      stall_cycles  = 0;
    end else begin
      if (in_valid_i && in_stall_o) stall_cycles++;
      if (out_valid_o && !out_stall_i) begin
        if (awaited_results.size() == 0) begin
          $error("result arrived with no request pending");
          error_count++;
        end else begin
          want = awaited_results.pop_front();
          compare_field("status", KeyW'(want.status), KeyW'(status_o));
          compare_field("hit", KeyW'(want.hit), KeyW'(hit_o));
          compare_field("hit_position", KeyW'(want.position), KeyW'(hit_position_o));
          compare_field("row_key", want.row_key, row_key_o);
          compare_field("row_len", KeyW'(want.row_len), KeyW'(row_len_o));
        end
      end
      if (in_valid_i && !in_stall_o) begin
        predict_mru_access(op_e'(operation_i), key_i, key_len_i, row_index_i, want);
        awaited_results.push_back(want);
        if (op_e'(operation_i) == OP_READ) read_count++;
        else if (want.status == STATUS_BAD_LEN) bad_len_count++;
        else begin
          insert_count++;
          if (want.hit) hit_count++;
        end
      end
    end
    pending = awaited_results.size();
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import mtfel_pkg::*;

  localparam int PoolSize = 12;

  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            in_valid_i  = 1'b0;
  logic            operation_i = 1'b0;
  key_t            key_i       = '0;
  len_t            key_len_i   = '0;
  logic [2:0]      row_index_i = '0;
  logic            out_stall_i = 1'b0;
  logic            in_stall_o;
  logic            out_valid_o;
  logic            status_o;
  logic            hit_o;
  logic [PosW-1:0] hit_position_o;
  key_t            row_key_o;
  len_t            row_len_o;

  int   error_count, pending, insert_count, hit_count, bad_len_count, read_count;
  int   stall_cycles;
  int   idle_pct   = 0;
  int   stall_pct  = 0;
  int   sent_count = 0;
  logic hold_off   = 1'b0;
  key_t recent_keys[PoolSize];
  len_t recent_lens[PoolSize];

  move_to_front_entry_list DUT (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .operation_i,
    .key_i,
    .key_len_i,
    .row_index_i,
    .out_valid_o,
    .out_stall_i,
    .status_o,
    .hit_o,
    .hit_position_o,
    .row_key_o,
    .row_len_o
  );

  mru_list_checker checker_i (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .operation_i,
    .key_i,
    .key_len_i,
    .row_index_i,
    .out_valid_o,
    .out_stall_i,
    .status_o,
    .hit_o,
    .hit_position_o,
    .row_key_o,
    .row_len_o,
    .error_count,
    .pending,
    .insert_count,
    .hit_count,
    .bad_len_count,
    .read_count,
    .stall_cycles
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_stall_i <= hold_off || ($urandom_range(99) < stall_pct);
  end

  // hold off the result side long enough to back up the request side
  initial begin
    wait (sent_count >= 60);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (50) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic send_request(input op_e op, input key_t key, input len_t len,
                              input logic [2:0] idx);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    key_i       <= key;
    key_len_i   <= len;
    row_index_i <= idx;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent_count++;
  endtask

  task automatic refresh_recent(input int slot);
    recent_keys[slot] = KeyW'({$urandom, $urandom});
    recent_lens[slot] = len_t'($urandom_range(1, KeyBytes));
  endtask

  task automatic send_random_request();
    int          pick;
    int          slot;
    key_t        noise;
    len_t        len;
    logic [63:0] m;
    pick  = $urandom_range(99);
    noise = KeyW'({$urandom, $urandom});
    if (pick < 25) begin
      send_request(OP_READ, noise, len_t'($urandom_range(7)), 3'($urandom_range(7)));
    end else if (pick < 30) begin
      send_request(OP_INSERT, noise, '0, 3'($urandom_range(7)));
    end else if (pick < 40) begin
      send_request(OP_INSERT, noise, len_t'($urandom_range(1, KeyBytes)),
                   3'($urandom_range(7)));
    end else begin
      // reuse a recent key, scramble the bytes past its length
      slot = $urandom_range(PoolSize - 1);
      if ($urandom_range(19) == 0) refresh_recent(slot);
      len = recent_lens[slot];
      m   = (64'd1 << (8 * len)) - 64'd1;
      send_request(OP_INSERT, (recent_keys[slot] & m[KeyW-1:0]) | (noise & ~m[KeyW-1:0]),
                   len, 3'($urandom_range(7)));
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(OP_READ, '0, '0, 3'd0);
    send_request(OP_READ, '1, '1, 3'd7);
    send_request(OP_INSERT, '1, 3'd0, 3'd0);
    send_request(OP_INSERT, '1, 3'd1, '0);
    send_request(OP_INSERT, 56'hFF_FFFF_FFFF_FF00, 3'd1, '0);
    send_request(OP_READ, '0, '0, 3'd0);
    send_request(OP_INSERT, '1, 3'd7, '0);
    send_request(OP_INSERT, '1, 3'd7, '0);
    send_request(OP_INSERT, 56'h12_3456_0000_AB00, 3'd1, '0);
    for (int i = 0; i < 5; i++) begin
      send_request(OP_INSERT, KeyW'({$urandom, $urandom}), len_t'(i + 2), '0);
    end
    send_request(OP_INSERT, 56'h00_0000_5A5A_A5FF, 3'd1, '0);
    send_request(OP_INSERT, 56'h00_0000_0000_00FF, 3'd2, '0);
    for (int i = 0; i < Entries; i++) begin
      send_request(OP_READ, '0, '0, 3'(i));
    end

    for (int s = 0; s < PoolSize; s++) refresh_recent(s);
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 58;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 58;
        end
        default: begin
          idle_pct  = 30;
          stall_pct = 30;
        end
      endcase
      repeat (325) send_random_request();
    end
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (8) @(posedge clk_i);

    $display("Sent %0d requests: %0d good inserts (%0d hits), %0d bad lengths, %0d reads.",
             sent_count, insert_count, hit_count, bad_len_count, read_count);
    $display("Request side was held off for %0d cycles over four idle and stall mixes.",
             stall_cycles);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== move_to_front_entry_list.f =====
src/mtfel_pkg.sv
src/move_to_front_entry_list.sv
bench/mru_list_checker.sv
bench/tb.sv
